>>> hw/rtl/decimal96_multiply_unit_assert.svh
// Assertion macros for the decimal multiply unit.
// Included by the top level; no other dependencies.
`ifndef DECIMAL96_MULTIPLY_UNIT_ASSERT_SVH
`define DECIMAL96_MULTIPLY_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define DM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define DM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/dm96_pkg.sv
// Shared constants of the decimal multiply unit.
// No dependencies.
package dm96_pkg;
  localparam int unsigned MantW = 96;
  localparam int unsigned ProdW = 192;
  localparam int unsigned MaxScale = 28;
  localparam logic [31:0] FlagReserved = 32'h7F00FFFF;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StBig = 2'd1;
  localparam logic [1:0] StSmall = 2'd2;
  localparam logic [1:0] StInvalid = 2'd3;
endpackage

>>> hw/rtl/dm96_mul.sv
// Bit-serial 96 x 96 shift-and-add multiplier, one multiplier bit per cycle.
// Depends on dm96_pkg.
module dm96_mul import dm96_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MantW-1:0]   a,
  input  logic [MantW-1:0]   b,
  output logic               done,
  output logic [ProdW-1:0]   prod
);
  logic [ProdW-1:0] acc_r, acc_nxt;
  logic [MantW-1:0] mcand_r;
  logic [6:0] cnt_r;
  logic busy_r;
  logic [MantW:0] sum;

  assign sum = {1'b0, acc_r[ProdW-1:MantW]} + (acc_r[0] ? {1'b0, mcand_r} : '0);
  assign acc_nxt = {sum, acc_r[MantW-1:1]};
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(MantW - 1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= {{MantW{1'b0}}, b};
      mcand_r <= a;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end
endmodule

>>> hw/rtl/dm96_div10.sv
// Divide-by-ten unit: divides the 192-bit word by ten, one 4-bit digit per
// cycle. Depends on dm96_pkg.
module dm96_div10 import dm96_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ProdW-1:0] x,
  output logic             done,
  output logic [ProdW-1:0] q,
  output logic [3:0]       rem
);
  logic [ProdW-1:0] sh_r;
  logic [3:0] r_r;
  logic [5:0] cnt_r;
  logic busy_r;
  logic [7:0] cur;
  logic [3:0] qd;
  logic [3:0] rn;
  logic [7:0] t0, t1, t2, t3;

  assign cur = {r_r, sh_r[ProdW-1 -: 4]};

  always_comb begin
    qd[3] = (cur >= 8'd80);
    t0 = qd[3] ? cur - 8'd80 : cur;
    qd[2] = (t0 >= 8'd40);
    t1 = qd[2] ? t0 - 8'd40 : t0;
    qd[1] = (t1 >= 8'd20);
    t2 = qd[1] ? t1 - 8'd20 : t1;
    qd[0] = (t2 >= 8'd10);
    t3 = qd[0] ? t2 - 8'd10 : t2;
  end

  assign rn = t3[3:0];
  assign q = sh_r;
  assign rem = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(ProdW / 4 - 1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r <= x;
      r_r <= '0;
    end else if (busy_r) begin
      sh_r <= {sh_r[ProdW-5:0], qd};
      r_r <= rn;
    end
  end
endmodule

>>> hw/rtl/decimal96_multiply_unit.sv
// Top level of the decimal multiply unit: control sequencer, operand check,
// rounding and output register. Depends on dm96_pkg, dm96_mul, dm96_div10.
//
// Channel | Direction | Contents
// in_     | slave     | tdata: a_mant_low, a_mant_high, a_flags, b_mant_low, b_mant_high, b_flags
// out_    | master    | tdata: p_mant_low, p_mant_high, p_flags, status
//
// After the bit-serial multiply, the product is divided by ten once per
// digit to drop, each division a 48-digit loop of the divider with its
// start and done handshake; up to 29 divisions are needed. An invalid item
// skips both and goes straight to the output state.
// One item is worked on at a time; in_tready is low while busy or while a
// result waits. Reset is synchronous and clears the sequencer and handshake state.
`include "decimal96_multiply_unit_assert.svh"
module decimal96_multiply_unit import dm96_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_mant_low, a_mant_high, a_flags, b_mant_low, b_mant_high, b_flags
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // p_mant_low, p_mant_high, p_flags, status, zero fill
  output logic [135:0] out_tdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r;
  logic [MantW-1:0] a_r, b_r;
  logic [31:0] fa_r, fb_r;
  logic [ProdW-1:0] p_r;
  logic [7:0] k_r;
  logic [7:0] need_r;
  logic [3:0] last_r;
  logic sticky_r, nz_r, fit_r;
  logic [135:0] out_r;
  logic mul_start_r, div_start_r, div_pend_r;
  logic mul_done, div_done;
  logic [ProdW-1:0] mprod, dq;
  logic [3:0] drem;
  logic [5:0] ssum;
  logic [7:0] need_c;
  logic [ProdW:0] rnd;
  logic do_up;
  logic sign;
  logic [7:0] rp;

  assign in_tready = (state_r == S_IDLE) && !out_tvalid;
  assign out_tdata = out_r;
  assign sign = fa_r[31] ^ fb_r[31];
  assign ssum = 6'(fa_r[23:16]) + 6'(fb_r[23:16]);

  dm96_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r), .a(a_r), .b(b_r),
    .done(mul_done), .prod(mprod)
  );
  dm96_div10 u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .x(p_r),
    .done(div_done), .q(dq), .rem(drem)
  );

  always_comb begin
    need_c = k_r;
    if (8'(ssum) > k_r && 8'(ssum) - k_r > 8'(MaxScale)) begin
      need_c = 8'(ssum) - 8'(MaxScale);
    end
  end

  assign do_up = (last_r > 4'd5) || (last_r == 4'd5 && (sticky_r || p_r[0]));
  assign rnd = {1'b0, p_r} + {{ProdW{1'b0}}, do_up};
  assign rp = 8'(ssum) - k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_tvalid <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      div_pend_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            a_r <= in_tdata[95:0];
            fa_r <= in_tdata[127:96];
            b_r <= in_tdata[223:128];
            fb_r <= in_tdata[255:224];
            if ((in_tdata[127:96] & FlagReserved) != 0 ||
                (in_tdata[255:224] & FlagReserved) != 0 ||
                in_tdata[119:112] > 8'(MaxScale) ||
                in_tdata[247:240] > 8'(MaxScale)) begin
              out_r <= {6'd0, StInvalid, 32'd0, {MantW{1'b1}}};
              state_r <= S_OUT;
            end else begin
              mul_start_r <= 1'b1;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            p_r <= mprod;
            nz_r <= (a_r != 0) && (b_r != 0);
            k_r <= '0;
            need_r <= '0;
            fit_r <= 1'b0;
            last_r <= '0;
            sticky_r <= 1'b0;
            div_pend_r <= 1'b0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            p_r <= dq;
            if (last_r != 0) sticky_r <= 1'b1;
            last_r <= drem;
            k_r <= k_r + 8'd1;
            div_pend_r <= 1'b0;
          end else if (!div_pend_r) begin
            if (!fit_r) begin
              if (p_r[ProdW-1:MantW] == 0) begin
                fit_r <= 1'b1;
                need_r <= need_c;
              end else begin
                div_start_r <= 1'b1;
                div_pend_r <= 1'b1;
              end
            end else if (8'(ssum) < k_r) begin
              out_r <= {6'd0, (sign ? StSmall : StBig), sign, 31'd0, {MantW{1'b1}}};
              state_r <= S_OUT;
            end else if (k_r >= need_r) begin
              state_r <= S_RND;
            end else begin
              div_start_r <= 1'b1;
              div_pend_r <= 1'b1;
            end
          end
        end
        S_RND: begin
          if (rnd[ProdW:MantW] != 0) begin
            out_r <= {6'd0, (sign ? StSmall : StBig), sign, 31'd0, {MantW{1'b1}}};
          end else begin
            out_r <= {6'd0, ((nz_r && rnd[MantW-1:0] == 0) ? StSmall : StOk),
                      sign, 7'd0, rp, 16'd0, rnd[MantW-1:0]};
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_tvalid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `DM_ASSERT_IMP(a_ready_idle, in_tready, state_r == S_IDLE)
  `DM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `DM_ASSERT_IMP(a_pend_in_div, div_pend_r, state_r == S_DIV)
endmodule

>>> verif/tb_top.sv
// Self-checking testbench for decimal96_multiply_unit: directed table, then random operands.
// Predicts each product with a bit-vector decimal multiply model; uses dm96_pkg and the DUT.
`timescale 1ns / 1ps
module tb_top import dm96_pkg::*;;

  typedef struct packed {
    logic [31:0] b_flags;
    logic [31:0] b_hi;
    logic [63:0] b_lo;
    logic [31:0] a_flags;
    logic [31:0] a_hi;
    logic [63:0] a_lo;
  } operands_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] p_flags;
    logic [31:0] p_hi;
    logic [63:0] p_lo;
  } product_t;

  typedef struct {
    operands_t ops;
    logic      has_exp;
    product_t  prod;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [255:0] in_tdata;
  logic [135:0] out_tdata;

  product_t expected_q[$];
  int mismatches, products_seen, idle_cycles;
  bit stim_done, hold_off;
  bit [3:0] status_hit;

  decimal96_multiply_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic product_t decimal_product(operands_t o);
    product_t r;
    logic [191:0] p, t;
    logic [31:0] sign;
    int sa, sb, k, n, rp;
    logic [3:0] last;
    bit sticky, nz;
    sa = o.a_flags[23:16];
    sb = o.b_flags[23:16];
    sign = (o.a_flags ^ o.b_flags) & 32'h8000_0000;
    if ((o.a_flags & FlagReserved) != 0 || (o.b_flags & FlagReserved) != 0 ||
        sa > MaxScale || sb > MaxScale) begin
      r.p_lo = '1; r.p_hi = '1; r.p_flags = '0; r.status = StInvalid;
      return r;
    end
    p = 192'({o.a_hi, o.a_lo}) * 192'({o.b_hi, o.b_lo});
    nz = ({o.a_hi, o.a_lo} != 0) && ({o.b_hi, o.b_lo} != 0);
    t = p;
    k = 0;
    while (t[191:96] != 0) begin
      t = t / 10;
      k++;
    end
    rp = sa + sb - k;
    sticky = 0;
    last = 0;
    if (rp >= 0) begin
      n = k;
      if (rp > MaxScale) begin
        n += rp - MaxScale;
        rp = MaxScale;
      end
      for (int i = 0; i < n; i++) begin
        if (last != 0) sticky = 1;
        last = 4'(p % 10);
        p = p / 10;
      end
      if (last > 5 || (last == 5 && (sticky || p[0]))) p = p + 1;
    end
    if (rp < 0 || p[191:96] != 0) begin
      r.p_lo = '1; r.p_hi = '1; r.p_flags = sign;
      r.status = (sign != 0) ? StSmall : StBig;
      return r;
    end
    r.p_lo = p[63:0];
    r.p_hi = p[95:64];
    r.p_flags = (32'(rp) << 16) | sign;
    r.status = (nz && p[95:0] == 0) ? StSmall : StOk;
    return r;
  endfunction

  function automatic logic [31:0] flag_word(int scale, bit neg);
    return {neg, 7'd0, 8'(scale), 16'd0};
  endfunction

  function automatic logic [95:0] rand_mant();
    logic [95:0] m;
    int w;
    m = {$urandom, $urandom, $urandom};
    w = $urandom_range(96, 1);
    if ($urandom_range(3, 0) != 0) m = m >> (96 - w);
    return m;
  endfunction

  function automatic operands_t rand_ops();
    operands_t o;
    logic [95:0] a, b;
    a = rand_mant();
    b = rand_mant();
    {o.a_hi, o.a_lo} = a;
    {o.b_hi, o.b_lo} = b;
    o.a_flags = flag_word($urandom_range(28, 0), $urandom_range(1, 0));
    o.b_flags = flag_word($urandom_range(28, 0), $urandom_range(1, 0));
    case ($urandom_range(19, 0))
      0: o.a_flags = $urandom;
      1: o.b_flags[23:16] = $urandom_range(255, 29);
      2: o.a_flags = o.a_flags | (32'h1 << $urandom_range(31, 0));
      default: ;
    endcase
    return o;
  endfunction

  function automatic operands_t mk(logic [95:0] a, logic [31:0] fa,
                                   logic [95:0] b, logic [31:0] fb);
    operands_t o;
    {o.a_hi, o.a_lo} = a;
    {o.b_hi, o.b_lo} = b;
    o.a_flags = fa;
    o.b_flags = fb;
    return o;
  endfunction

  task automatic send(operands_t o);
    int gap;
    gap = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(2, 0);
    if ($urandom_range(3, 0) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= o;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(decimal_product(o));
    @(negedge clk);
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    logic [95:0] ones;
    ones = '1;
    in_tvalid = 1'b0;
    in_tdata = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    r.has_exp = 1;
    r.ops = mk(0, flag_word(0, 0), 0, flag_word(0, 0));
    r.prod = '{StOk, 32'h0, 32'h0, 64'h0}; rows.push_back(r);
    r.ops = mk(0, flag_word(0, 1), 5, flag_word(3, 0));
    r.prod = '{StOk, 32'h8003_0000, 32'h0, 64'h0}; rows.push_back(r);
    r.ops = mk(7, flag_word(29, 0), 1, flag_word(0, 0));
    r.prod = '{StInvalid, 32'h0, '1, '1}; rows.push_back(r);
    r.ops = mk(7, 32'h0000_0001, 1, flag_word(0, 0));
    r.prod = '{StInvalid, 32'h0, '1, '1}; rows.push_back(r);
    r.ops = mk(7, flag_word(0, 0), 1, 32'h4000_0000);
    r.prod = '{StInvalid, 32'h0, '1, '1}; rows.push_back(r);
    r.ops = mk(ones, flag_word(0, 0), 2, flag_word(0, 0));
    r.prod = '{StBig, 32'h0, '1, '1}; rows.push_back(r);
    r.ops = mk(ones, flag_word(0, 1), 2, flag_word(0, 0));
    r.prod = '{StSmall, 32'h8000_0000, '1, '1}; rows.push_back(r);
    r.ops = mk(1, flag_word(28, 0), 1, flag_word(28, 0));
    r.prod = '{StSmall, 32'h001C_0000, 32'h0, 64'h0}; rows.push_back(r);
    r.ops = mk(3, flag_word(2, 1), 4, flag_word(1, 1));
    r.prod = '{StOk, 32'h0003_0000, 32'h0, 64'd12}; rows.push_back(r);
    r.has_exp = 0;
    r.ops = mk(ones, flag_word(28, 0), ones, flag_word(28, 1)); rows.push_back(r);
    r.ops = mk(ones, flag_word(14, 0), ones, flag_word(14, 0)); rows.push_back(r);
    r.ops = mk(5, flag_word(28, 0), 1, flag_word(1, 0)); rows.push_back(r);
    r.ops = mk(15, flag_word(28, 0), 1, flag_word(1, 0)); rows.push_back(r);
    r.ops = mk(51, flag_word(28, 0), 1, flag_word(2, 0)); rows.push_back(r);
    r.ops = mk(ones, flag_word(0, 0), 1, flag_word(0, 0)); rows.push_back(r);
    r.ops = mk(96'h1_0000_0000_0000_0000, flag_word(10, 1), ones, flag_word(28, 0));
    rows.push_back(r);

    foreach (rows[i]) begin
      send(rows[i].ops);
      if (rows[i].has_exp) expected_q[$] = rows[i].prod;
    end
    for (int n = 0; n < 950; n++) begin
      if (n == 300) hold_off = 1;
      send(rand_ops());
    end
    in_tvalid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end else if ($urandom_range(15, 0) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(60, 1)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(5, 0) != 0) || ($urandom_range(1, 0) == 1);
      end
    end
  end

  always @(posedge clk) begin
    product_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = product_t'(out_tdata[129:0]);
      products_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected product transfer %h", got);
      end else begin
        want = expected_q.pop_front();
        status_hit[got.status] = 1;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp lo %h hi %h fl %h st %0d / got lo %h hi %h fl %h st %0d",
                     want.p_lo, want.p_hi, want.p_flags, want.status,
                     got.p_lo, got.p_hi, got.p_flags, got.status);
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("watchdog expired with %0d products pending", expected_q.size());
        $display("tb: failure");
        $finish;
      end
      if (stim_done && expected_q.size() == 0) begin
        repeat (50) @(posedge clk);
        $display("covered %0d products, status codes seen mask %b, %0d mismatches",
                 products_seen, status_hit, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
          $display("tb: success");
        end else begin
          $display("tb: failure");
        end
        $finish;
      end
    end
  end
endmodule

>>> decimal96_multiply_unit.f
+incdir+hw/rtl
hw/rtl/dm96_pkg.sv
hw/rtl/dm96_mul.sv
hw/rtl/dm96_div10.sv
hw/rtl/decimal96_multiply_unit.sv
verif/tb_top.sv
